/* sv/abl_pkg.sv */
// abl_pkg: shared types, delimiter constants and helpers for the armor block locator
// no dependencies; used by every other file of the block but abl_chan_if

package abl_pkg;

	localparam int ABL_WINDOW_BYTES = 37;
	localparam int ABL_OFFSET_BITS  = 32;
	localparam int LEN_BITS         = 6;

	localparam logic [7:0] CHAR_CR = 8'd13;
	localparam logic [7:0] CHAR_LF = 8'd10;

	// delimiter_mode codes
	localparam logic [1:0] MODE_SIGNED    = 2'd0;
	localparam logic [1:0] MODE_ENCRYPTED = 2'd1;
	localparam logic [1:0] MODE_PUBKEY    = 2'd2;

	// three-letter product tag that sits inside every delimiter
	localparam logic [23:0] TAG = 24'h504750;

	localparam int BEG_SIGNED_LEN    = 34;
	localparam int END_SIGNED_LEN    = 27;
	localparam int BEG_ENCRYPTED_LEN = 27;
	localparam int END_ENCRYPTED_LEN = 25;
	localparam int BEG_PUBKEY_LEN    = 36;
	localparam int END_PUBKEY_LEN    = 34;

	// first character in the top byte, so the newest window byte lines up with bits [7:0]
	localparam logic [8*BEG_SIGNED_LEN-1:0] BEG_SIGNED =
		{"-----BEGIN ", TAG, " SIGNED MESSAGE-----"};
	localparam logic [8*END_SIGNED_LEN-1:0] END_SIGNED =
		{"-----END ", TAG, " SIGNATURE-----"};
	localparam logic [8*BEG_ENCRYPTED_LEN-1:0] BEG_ENCRYPTED =
		{"-----BEGIN ", TAG, " MESSAGE-----"};
	localparam logic [8*END_ENCRYPTED_LEN-1:0] END_ENCRYPTED =
		{"-----END ", TAG, " MESSAGE-----"};
	localparam logic [8*BEG_PUBKEY_LEN-1:0] BEG_PUBKEY =
		{"-----BEGIN ", TAG, " PUBLIC KEY BLOCK-----"};
	localparam logic [8*END_PUBKEY_LEN-1:0] END_PUBKEY =
		{"-----END ", TAG, " PUBLIC KEY BLOCK-----"};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        found;
		logic [31:0] block_start;
		logic [31:0] block_size;
	} result_t;

	typedef logic [1:0] mode_t;

	// window compare flags for the byte in the input register
	typedef struct packed {
		logic                begin_hit;
		logic                begin_eol;
		logic [LEN_BITS-1:0] begin_len;
		logic                end_hit;
		logic                end_eol;
		logic [LEN_BITS-1:0] end_len;
	} match_t;

	typedef enum logic [2:0] {
		PH_BEGIN     = 3'd0,
		PH_END       = 3'd1,
		PH_AFTER_END = 3'd2,
		PH_AFTER_CR  = 3'd3,
		PH_DONE      = 3'd4
	} phase_t;

	function automatic logic is_eol(input logic [7:0] c);
		return (c == CHAR_CR) || (c == CHAR_LF);
	endfunction

endpackage

/* sv/abl_chan_if.sv */
// abl_chan_if: valid/ready channel with a typed payload
// no dependencies; the payload type is set per instance

interface abl_chan_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* sv/armor_block_locator_top.sv */
// armor_block_locator_top: locates one ascii-armored block per byte buffer
// depends on abl_pkg, abl_chan_if, abl_window and abl_tracker
//
// usage: bytes arrive on stream, one per transaction, last_byte set on the final
// byte of a buffer. for each buffer one transaction leaves on result: found, the
// offset of the begin delimiter and the block size including one trailing line
// end. cfg carries delimiter_mode (0 signed, 1 encrypted, 2 public key) and is
// always ready; write it only while no buffer is in flight.
// throughput is one byte per cycle while no last byte waits on a stalled result; a
// byte enters an input register, and the window compare plus the phase update run
// in the following cycle unless it is such a waiting last byte. a last byte then
// loads the result register, from which result.valid rises.
// if result is stalled, ordinary bytes keep flowing; only the next buffer's last
// byte waits in the input register until the pending result is taken, and
// stream.ready drops while it waits.
// reset sets delimiter_mode to 1, empties the byte history and starts a new
// buffer at offset 0. offsets saturate at 2^OFFSET_BITS - 1.

module armor_block_locator_top #(
	parameter int WINDOW_BYTES = abl_pkg::ABL_WINDOW_BYTES,
	parameter int OFFSET_BITS  = abl_pkg::ABL_OFFSET_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	abl_chan_if.sink   stream,
	abl_chan_if.sink   cfg,
	abl_chan_if.source result
);
	import abl_pkg::*;

	mode_t    mode_q;
	logic     valid_s1;
	in_item_t item_s1;
	logic     advance;
	logic     out_free;
	match_t   match;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENCRYPTED;
		end else if (cfg.valid) begin
			mode_q <= mode_t'(cfg.payload);
		end
	end

	// a last byte only moves on once the result register is free
	assign advance      = valid_s1 && (!item_s1.last_byte || out_free);
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			item_s1 <= stream.payload;
		end
	end

	abl_window #(
		.WINDOW_BYTES(WINDOW_BYTES)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.data_byte (item_s1.data_byte),
		.last_byte (item_s1.last_byte),
		.mode      (mode_q),
		.match     (match)
	);

	abl_tracker #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.data_byte (item_s1.data_byte),
		.last_byte (item_s1.last_byte),
		.match     (match),
		.out_free  (out_free),
		.result    (result)
	);

endmodule

/* sv/abl_window.sv */
// abl_window: byte history shift line and parallel delimiter compare
// depends on abl_pkg

module abl_window #(
	parameter int WINDOW_BYTES = abl_pkg::ABL_WINDOW_BYTES
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic [7:0]      data_byte,
	input  logic            last_byte,
	input  abl_pkg::mode_t  mode,
	output abl_pkg::match_t match
);
	import abl_pkg::*;

	logic [7:0]              win_q [WINDOW_BYTES-1];
	logic [8*WINDOW_BYTES-1:0] cur_vec;

	// window as it stands once the current byte is shifted in, newest in [7:0]
	always_comb begin
		cur_vec[7:0] = data_byte;
		for (int i = 1; i < WINDOW_BYTES; i++) begin
			cur_vec[8*i +: 8] = win_q[i-1];
		end
	end

	always_comb begin
		match = '0;
		case (mode)
			MODE_SIGNED: begin
				match.begin_hit = cur_vec[8*BEG_SIGNED_LEN-1:0] == BEG_SIGNED;
				match.begin_eol = is_eol(cur_vec[8*BEG_SIGNED_LEN +: 8]);
				match.begin_len = LEN_BITS'(BEG_SIGNED_LEN);
				match.end_hit   = cur_vec[8*END_SIGNED_LEN-1:0] == END_SIGNED;
				match.end_eol   = is_eol(cur_vec[8*END_SIGNED_LEN +: 8]);
				match.end_len   = LEN_BITS'(END_SIGNED_LEN);
			end
			MODE_ENCRYPTED: begin
				match.begin_hit = cur_vec[8*BEG_ENCRYPTED_LEN-1:0] == BEG_ENCRYPTED;
				match.begin_eol = is_eol(cur_vec[8*BEG_ENCRYPTED_LEN +: 8]);
				match.begin_len = LEN_BITS'(BEG_ENCRYPTED_LEN);
				match.end_hit   = cur_vec[8*END_ENCRYPTED_LEN-1:0] == END_ENCRYPTED;
				match.end_eol   = is_eol(cur_vec[8*END_ENCRYPTED_LEN +: 8]);
				match.end_len   = LEN_BITS'(END_ENCRYPTED_LEN);
			end
			MODE_PUBKEY: begin
				match.begin_hit = cur_vec[8*BEG_PUBKEY_LEN-1:0] == BEG_PUBKEY;
				match.begin_eol = is_eol(cur_vec[8*BEG_PUBKEY_LEN +: 8]);
				match.begin_len = LEN_BITS'(BEG_PUBKEY_LEN);
				match.end_hit   = cur_vec[8*END_PUBKEY_LEN-1:0] == END_PUBKEY;
				match.end_eol   = is_eol(cur_vec[8*END_PUBKEY_LEN +: 8]);
				match.end_len   = LEN_BITS'(END_PUBKEY_LEN);
			end
			default: begin
				match = '0;
			end
		endcase
	end

	// history restarts empty after the last byte of a buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_BYTES-1; i++) begin
				win_q[i] <= '0;
			end
		end else if (advance) begin
			if (last_byte) begin
				for (int i = 0; i < WINDOW_BYTES-1; i++) begin
					win_q[i] <= '0;
				end
			end else begin
				win_q[0] <= data_byte;
				for (int i = 1; i < WINDOW_BYTES-1; i++) begin
					win_q[i] <= win_q[i-1];
				end
			end
		end
	end

endmodule

/* sv/abl_tracker.sv */
// abl_tracker: search phase, offset bookkeeping and the result register
// depends on abl_pkg, abl_chan_if and the match flags from abl_window

module abl_tracker #(
	parameter int OFFSET_BITS = abl_pkg::ABL_OFFSET_BITS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic [7:0]      data_byte,
	input  logic            last_byte,
	input  abl_pkg::match_t match,
	output logic            out_free,
	abl_chan_if.source      result
);
	import abl_pkg::*;

	localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;

	phase_t                 phase_q, phase_d;
	logic [OFFSET_BITS-1:0] offset_q, start_q, floor_q, end_q;
	logic [OFFSET_BITS-1:0] start_d, floor_d, end_d;
	logic [OFFSET_BITS-1:0] next_ofs, end_inc, len_m1, st, size_ofs;
	logic                   sel_hit, sel_eol, cand, begin_take, end_take, found_d;
	logic [LEN_BITS-1:0]    sel_len;
	result_t                result_q;
	logic                   out_valid_q;

	assign next_ofs = (offset_q == OFS_MAX) ? offset_q : offset_q + OFFSET_BITS'(1);
	assign end_inc  = (end_q == OFS_MAX) ? end_q : end_q + OFFSET_BITS'(1);

	assign sel_hit = (phase_q == PH_END) ? match.end_hit : match.begin_hit;
	assign sel_eol = (phase_q == PH_END) ? match.end_eol : match.begin_eol;
	assign sel_len = (phase_q == PH_END) ? match.end_len : match.begin_len;

	// match start offset; a match must fit in the buffer and lie past the last one
	assign len_m1     = OFFSET_BITS'(sel_len) - OFFSET_BITS'(1);
	assign st         = offset_q - len_m1;
	assign cand       = sel_hit && (offset_q >= len_m1) && (st >= floor_q);
	assign begin_take = cand && ((st == '0) || sel_eol);
	assign end_take   = cand && (st != '0) && sel_eol;

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_BEGIN: begin
				if (begin_take) begin
					phase_d = PH_END;
				end
			end
			PH_END: begin
				if (end_take) begin
					phase_d = PH_AFTER_END;
				end
			end
			PH_AFTER_END: begin
				phase_d = (data_byte == CHAR_CR) ? PH_AFTER_CR : PH_DONE;
			end
			PH_AFTER_CR: begin
				phase_d = PH_DONE;
			end
			PH_DONE: begin
				phase_d = PH_DONE;
			end
			default: begin
				phase_d = PH_BEGIN;
			end
		endcase
	end

	always_comb begin
		start_d = start_q;
		floor_d = floor_q;
		end_d   = end_q;
		case (phase_q)
			PH_BEGIN: begin
				if (cand) begin
					floor_d = next_ofs;
				end
				if (begin_take) begin
					start_d = st;
				end
			end
			PH_END: begin
				if (cand) begin
					floor_d = next_ofs;
				end
				if (end_take) begin
					end_d = next_ofs;
				end
			end
			PH_AFTER_END: begin
				if (data_byte == CHAR_CR || data_byte == CHAR_LF) begin
					end_d = end_inc;
				end
			end
			PH_AFTER_CR: begin
				if (data_byte == CHAR_LF) begin
					end_d = end_inc;
				end
			end
			default: begin
				end_d = end_q;
			end
		endcase
	end

	assign found_d  = (phase_d == PH_AFTER_END) || (phase_d == PH_AFTER_CR) ||
		(phase_d == PH_DONE);
	assign size_ofs = end_d - start_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_BEGIN;
			offset_q <= '0;
			start_q  <= '0;
			floor_q  <= '0;
			end_q    <= '0;
		end else if (advance) begin
			if (last_byte) begin
				phase_q  <= PH_BEGIN;
				offset_q <= '0;
				start_q  <= '0;
				floor_q  <= '0;
				end_q    <= '0;
			end else begin
				phase_q  <= phase_d;
				offset_q <= next_ofs;
				start_q  <= start_d;
				floor_q  <= floor_d;
				end_q    <= end_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_byte) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_byte) begin
			result_q.found       <= found_d;
			result_q.block_start <= found_d ? 32'(start_d) : 32'd0;
			result_q.block_size  <= found_d ? 32'(size_ofs) : 32'd0;
		end
	end

	assign out_free       = !out_valid_q || result.ready;
	assign result.valid   = out_valid_q;
	assign result.payload = result_q;

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_byte |=> offset_q == '0 && phase_q == PH_BEGIN)
		else $error("buffer state not cleared after last byte");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_byte |=> out_valid_q)
		else $error("last byte did not load the result register");

	a_floor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		floor_q <= offset_q && start_q <= offset_q)
		else $error("match floor or start beyond byte offset");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_q.found |-> result_q.block_start == 32'd0 &&
			result_q.block_size == 32'd0)
		else $error("not-found result carries nonzero fields");

endmodule

/* verif/testbench.sv */
// testbench for armor_block_locator_top: streams byte buffers, predicts the located block
// depends on abl_pkg, abl_chan_if and the armor_block_locator_top rtl

module testbench;
	import abl_pkg::*;

	localparam int          WIN_BYTES   = 37;
	localparam int          PAT_BITS    = 8 * 36;
	localparam int          SETTLE      = 8;
	localparam int          HOLD_CYCLES = 300;
	localparam int          PHASES      = 9;
	localparam int          PHASE_BYTES = 120;
	localparam longint      CYCLE_LIMIT = 400000;
	localparam int          MAX_REPORTS = 10;
	localparam logic [23:0] ARMOR_TAG   = 24'h504750;
	localparam mode_t       MODE_NONE   = 2'd3;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	abl_chan_if #(.payload_t(in_item_t)) stream_ch ();
	abl_chan_if #(.payload_t(mode_t))    cfg_ch ();
	abl_chan_if #(.payload_t(result_t))  result_ch ();

	armor_block_locator_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.cfg    (cfg_ch),
		.result (result_ch)
	);

	in_item_t    bytes_to_send [$];
	result_t     blocks_due [$];
	logic [7:0]  text_q [$];
	int unsigned idle_pct   = 0;
	int unsigned send_gap   = 0;
	int unsigned recv_stall = 0;
	int unsigned err_count  = 0;
	longint      cycles     = 0;
	bit          hold_go    = 1'b0;
	logic        hold_off   = 1'b0;

	// locator state, mirrored byte by byte
	mode_t       mode_now;
	logic [7:0]  hist [0:WIN_BYTES-1];
	phase_t      trk_phase;
	logic [31:0] trk_ofs;
	logic [31:0] trk_start;
	logic [31:0] trk_floor;
	logic [31:0] trk_end;

	initial forever #1 clk = ~clk;

	// delimiter text right-justified: the last character sits in bits [7:0]
	function automatic void delimiter_text(input mode_t m, input bit is_end,
			output logic [PAT_BITS-1:0] pat, output int unsigned len);
		pat = '0;
		len = 0;
		case (m)
			MODE_SIGNED: if (!is_end) begin
				pat = PAT_BITS'({"-----BEGIN ", ARMOR_TAG, " SIGNED MESSAGE-----"});
				len = 34;
			end else begin
				pat = PAT_BITS'({"-----END ", ARMOR_TAG, " SIGNATURE-----"});
				len = 27;
			end
			MODE_ENCRYPTED: if (!is_end) begin
				pat = PAT_BITS'({"-----BEGIN ", ARMOR_TAG, " MESSAGE-----"});
				len = 27;
			end else begin
				pat = PAT_BITS'({"-----END ", ARMOR_TAG, " MESSAGE-----"});
				len = 25;
			end
			MODE_PUBKEY: if (!is_end) begin
				pat = PAT_BITS'({"-----BEGIN ", ARMOR_TAG, " PUBLIC KEY BLOCK-----"});
				len = 36;
			end else begin
				pat = PAT_BITS'({"-----END ", ARMOR_TAG, " PUBLIC KEY BLOCK-----"});
				len = 34;
			end
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] sat_next(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	function automatic void clear_tracker();
		foreach (hist[k]) hist[k] = 8'd0;
		trk_phase = PH_BEGIN;
		trk_ofs   = '0;
		trk_start = '0;
		trk_floor = '0;
		trk_end   = '0;
	endfunction

	function automatic void track_armor_byte(input logic [7:0] b, input logic last);
		logic [31:0]         n;
		logic [31:0]         nxt;
		logic [32:0]         st;
		logic [PAT_BITS-1:0] pat;
		int unsigned         len;
		bit                  want_end;
		bit                  hit;
		bit                  eol_before;
		result_t             r;
		n   = trk_ofs;
		nxt = sat_next(n);
		for (int k = WIN_BYTES - 1; k > 0; k--) hist[k] = hist[k-1];
		hist[0] = b;
		case (trk_phase)
			PH_AFTER_END: begin
				if (b == CHAR_CR) begin
					trk_end   = sat_next(trk_end);
					trk_phase = PH_AFTER_CR;
				end else if (b == CHAR_LF) begin
					trk_end   = sat_next(trk_end);
					trk_phase = PH_DONE;
				end else begin
					trk_phase = PH_DONE;
				end
			end
			PH_AFTER_CR: begin
				if (b == CHAR_LF) trk_end = sat_next(trk_end);
				trk_phase = PH_DONE;
			end
			PH_BEGIN, PH_END: if (mode_now != MODE_NONE) begin
				want_end = (trk_phase == PH_END);
				delimiter_text(mode_now, want_end, pat, len);
				hit = (len != 0) && ({1'b0, n} + 33'd1 >= len);
				for (int k = 0; k < len; k++)
					if (hist[k] != pat[8*k +: 8]) hit = 1'b0;
				if (hit) begin
					st = {1'b0, n} + 33'd1 - len;
					eol_before = (hist[len] == CHAR_CR) || (hist[len] == CHAR_LF);
					// a match overlapping the previous one is skipped
					if (st >= {1'b0, trk_floor}) begin
						if (!want_end && (st == 0 || eol_before)) begin
							trk_start = st[31:0];
							trk_phase = PH_END;
						end else if (want_end && st != 0 && eol_before) begin
							trk_end   = nxt;
							trk_phase = PH_AFTER_END;
						end
						trk_floor = nxt;
					end
				end
			end
			default: ;
		endcase
		trk_ofs = nxt;
		if (last) begin
			r = '0;
			if (trk_phase == PH_AFTER_END || trk_phase == PH_AFTER_CR || trk_phase == PH_DONE) begin
				r.found       = 1'b1;
				r.block_start = trk_start;
				r.block_size  = trk_end - trk_start;
			end
			blocks_due.push_back(r);
			clear_tracker();
		end
	endfunction

	function automatic void put_delim(input mode_t m, input bit is_end, input int unsigned skip);
		logic [PAT_BITS-1:0] pat;
		int unsigned         len;
		delimiter_text(m, is_end, pat, len);
		for (int i = skip; i < len; i++) text_q.push_back(pat[8*(len-1-i) +: 8]);
	endfunction

	function automatic void put_text(input int unsigned n);
		for (int i = 0; i < n; i++)
			if ($urandom_range(0, 9) == 0) text_q.push_back(8'($urandom_range(0, 255)));
			else text_q.push_back(8'($urandom_range(32, 126)));
	endfunction

	function automatic void put_eol();
		case ($urandom_range(0, 2))
			0: text_q.push_back(CHAR_CR);
			1: text_q.push_back(CHAR_LF);
			default: begin
				text_q.push_back(CHAR_CR);
				text_q.push_back(CHAR_LF);
			end
		endcase
	endfunction

	function automatic int unsigned flush_buffer();
		int unsigned n;
		n = text_q.size();
		for (int i = 0; i < n; i++)
			bytes_to_send.push_back(in_item_t'{data_byte: text_q[i], last_byte: (i == n - 1)});
		text_q.delete();
		return n;
	endfunction

	// kind 0 is pure noise, 1 a jumble of pieces, anything else a mostly well-formed block
	function automatic int unsigned make_buffer(input mode_t m, input int unsigned kind);
		int unsigned tail;
		int unsigned idx;
		if (kind == 0) begin
			repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
		end else if (kind == 1) begin
			repeat ($urandom_range(1, 5))
				case ($urandom_range(0, 2))
					0: put_text($urandom_range(1, 10));
					1: put_eol();
					default: put_delim(mode_t'($urandom_range(0, 2)),
						1'($urandom_range(0, 1)), 0);
				endcase
		end else begin
			case ($urandom_range(0, 4))
				0: ;
				1: begin
					put_text($urandom_range(0, 12));
					put_eol();
				end
				2: begin
					put_text($urandom_range(1, 8));
					put_delim(m, 1'b0, 0);
					put_eol();
				end
				3: begin
					put_eol();
					put_text($urandom_range(0, 3));
					put_delim(m, 1'b0, 0);
					put_delim(m, 1'b0, 5);
					put_eol();
				end
				default: begin
					put_text($urandom_range(0, 6));
					put_delim(mode_t'($urandom_range(0, 2)), 1'b0, 0);
					put_eol();
				end
			endcase
			put_delim(($urandom_range(0, 9) == 0) ? mode_t'($urandom_range(0, 2)) : m, 1'b0, 0);
			repeat ($urandom_range(0, 3)) begin
				put_eol();
				put_text($urandom_range(0, 20));
			end
			if ($urandom_range(0, 4) == 0) begin
				put_text($urandom_range(1, 4));
				put_delim(m, 1'b1, 0);
			end
			if ($urandom_range(0, 9) != 0) put_eol();
			put_delim(m, 1'b1, 0);
			tail = $urandom_range(0, 6);
			case (tail)
				0: ;
				1: text_q.push_back(CHAR_CR);
				2: text_q.push_back(CHAR_LF);
				3: begin
					text_q.push_back(CHAR_CR);
					text_q.push_back(CHAR_LF);
				end
				4: begin
					text_q.push_back(CHAR_CR);
					put_text(1);
				end
				5: begin
					text_q.push_back(CHAR_LF);
					text_q.push_back(CHAR_CR);
				end
				default: put_text(1);
			endcase
			if (tail > 1 && $urandom_range(0, 1) == 0) begin
				put_text($urandom_range(0, 10));
				// a second block in the same buffer must be ignored
				if ($urandom_range(0, 1) == 0) begin
					put_eol();
					put_delim(m, 1'b0, 0);
					put_eol();
					put_delim(m, 1'b1, 0);
				end
			end
			if ($urandom_range(0, 9) == 0) begin
				idx = $urandom_range(0, text_q.size() - 1);
				text_q[idx] = text_q[idx] ^ (8'd1 << $urandom_range(0, 7));
			end
		end
		return flush_buffer();
	endfunction

	task automatic flag_error(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS) $display("mismatch: %s", msg);
	endtask

	task automatic write_mode(input mode_t m);
		@(posedge clk);
		cfg_ch.valid   <= 1'b1;
		cfg_ch.payload <= m;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		mode_now = m;
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (bytes_to_send.size() != 0 || stream_ch.valid || blocks_due.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// byte sender
	always @(posedge clk) begin
		if (!arst_n) begin
			stream_ch.valid <= 1'b0;
		end else begin
			if (stream_ch.valid && stream_ch.ready)
				track_armor_byte(stream_ch.payload.data_byte, stream_ch.payload.last_byte);
			if (!stream_ch.valid || stream_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					stream_ch.valid <= 1'b0;
				end else if (bytes_to_send.size() == 0) begin
					stream_ch.valid <= 1'b0;
				end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
					send_gap = $urandom_range(0, 4);
					stream_ch.valid <= 1'b0;
				end else begin
					stream_ch.payload <= bytes_to_send.pop_front();
					stream_ch.valid   <= 1'b1;
				end
			end
		end
	end

	// result checker and receiver stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (blocks_due.size() == 0) begin
					flag_error($sformatf("result with nothing expected: found=%0d start=%0d size=%0d",
						result_ch.payload.found, result_ch.payload.block_start,
						result_ch.payload.block_size));
				end else begin
					if (result_ch.payload.found !== blocks_due[0].found)
						flag_error($sformatf("found exp %0d got %0d",
							blocks_due[0].found, result_ch.payload.found));
					if (result_ch.payload.block_start !== blocks_due[0].block_start)
						flag_error($sformatf("block_start exp %0d got %0d",
							blocks_due[0].block_start, result_ch.payload.block_start));
					if (result_ch.payload.block_size !== blocks_due[0].block_size)
						flag_error($sformatf("block_size exp %0d got %0d",
							blocks_due[0].block_size, result_ch.payload.block_size));
					void'(blocks_due.pop_front());
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				result_ch.ready <= 1'b0;
			end else if (hold_off) begin
				result_ch.ready <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				recv_stall = $urandom_range(0, 4);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// long receiver hold-off so the block backs up into the byte stream
	initial begin : receiver_hold
		wait (hold_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : stimulus
		mode_t       mode_plan [0:3];
		mode_t       m;
		mode_t       content_mode;
		int unsigned phase_bytes;
		mode_plan = '{MODE_SIGNED, MODE_PUBKEY, MODE_NONE, MODE_ENCRYPTED};
		stream_ch.valid   = 1'b0;
		stream_ch.payload = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.payload    = '0;
		result_ch.ready   = 1'b0;
		mode_now = MODE_ENCRYPTED;
		clear_tracker();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed buffers under the reset mode
		@(negedge clk);
		idle_pct = 20;
		text_q.push_back(8'h00);
		void'(flush_buffer());
		text_q.push_back(8'hFF);
		void'(flush_buffer());
		// begin at offset zero, full cr lf after the end delimiter
		put_delim(MODE_ENCRYPTED, 1'b0, 0);
		text_q.push_back(CHAR_LF);
		put_text(6);
		text_q.push_back(CHAR_CR);
		text_q.push_back(CHAR_LF);
		put_delim(MODE_ENCRYPTED, 1'b1, 0);
		text_q.push_back(CHAR_CR);
		text_q.push_back(CHAR_LF);
		void'(flush_buffer());
		// mid-line begin rejected, buffer cut right after the end delimiter
		put_text(2);
		put_delim(MODE_ENCRYPTED, 1'b0, 0);
		text_q.push_back(CHAR_LF);
		put_delim(MODE_ENCRYPTED, 1'b0, 0);
		text_q.push_back(CHAR_LF);
		put_delim(MODE_ENCRYPTED, 1'b1, 0);
		void'(flush_buffer());
		// buffer cut after the trailing cr
		text_q.push_back(CHAR_CR);
		put_delim(MODE_ENCRYPTED, 1'b0, 0);
		text_q.push_back(CHAR_LF);
		put_delim(MODE_ENCRYPTED, 1'b1, 0);
		text_q.push_back(CHAR_CR);
		void'(flush_buffer());
		// mid-line end rejected, later one taken with lf and text after
		text_q.push_back(CHAR_LF);
		put_delim(MODE_ENCRYPTED, 1'b0, 0);
		text_q.push_back(CHAR_LF);
		put_text(2);
		put_delim(MODE_ENCRYPTED, 1'b1, 0);
		text_q.push_back(CHAR_LF);
		put_delim(MODE_ENCRYPTED, 1'b1, 0);
		text_q.push_back(CHAR_LF);
		put_text(4);
		void'(flush_buffer());
		// other pair's delimiters and a begin with no end: nothing found
		put_delim(MODE_PUBKEY, 1'b0, 0);
		text_q.push_back(CHAR_LF);
		put_delim(MODE_PUBKEY, 1'b1, 0);
		text_q.push_back(CHAR_LF);
		put_delim(MODE_ENCRYPTED, 1'b0, 0);
		put_delim(MODE_ENCRYPTED, 1'b0, 5);
		void'(flush_buffer());
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			m = (p < 4) ? mode_plan[p] : mode_t'($urandom_range(0, 3));
			write_mode(m);
			content_mode = (m == MODE_NONE) ? mode_t'($urandom_range(0, 2)) : m;
			@(negedge clk);
			phase_bytes = 0;
			if (p == 4) begin
				idle_pct = 0;
				hold_go  = 1'b1;
				repeat (8) phase_bytes += make_buffer(content_mode, 0);
			end else if (p >= PHASES - 2) begin
				idle_pct = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 15;
					default: idle_pct = 40;
				endcase
			end
			while (phase_bytes < PHASE_BYTES)
				phase_bytes += make_buffer(content_mode, $urandom_range(0, 9));
			wait_idle();
		end

		if (err_count == 0 && blocks_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* armor_block_locator_top.f */
sv/abl_pkg.sv
sv/abl_chan_if.sv
sv/abl_window.sv
sv/abl_tracker.sv
sv/armor_block_locator_top.sv
verif/testbench.sv
